FILE: hw/rtl/le_pkg.sv
package le_pkg;

    // field widths fixed by the message format
    localparam int ID_W        = 8;
    localparam int TICKS_W     = 7;
    localparam int PERIOD_W    = 6;
    localparam int WAIT_W      = 8;   // signed, -1 .. 127
    localparam int SEND_W      = 7;   // 0 .. 2 * 63
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 16;

    localparam int ID_BITS_DEF = 8;

    // register reset values
    localparam logic [ID_W-1:0]     MY_ID_RST     = 8'd2;
    localparam logic [TICKS_W-1:0]  ELECT_RST     = 7'd15;
    localparam logic [TICKS_W-1:0]  LEADER_RST    = 7'd30;
    localparam logic [PERIOD_W-1:0] SEND_RST      = 6'd3;
    localparam logic [PERIOD_W-1:0] HEARTBEAT_RST = 6'd1;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_MSG  = 1'b1;

    typedef enum logic [1:0] {
        ROLE_ELECTION = 2'd0,
        ROLE_LEADER   = 2'd1,
        ROLE_FOLLOWER = 2'd2
    } t_role;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MY_ID       = 3'd0,
        CFG_ELECT_TICKS = 3'd1,
        CFG_LEAD_TICKS  = 3'd2,
        CFG_SEND_PERIOD = 3'd3,
        CFG_HB_PERIOD   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ID_W-1:0]     my_id;
        logic [TICKS_W-1:0]  election_ticks;
        logic [TICKS_W-1:0]  leader_ticks;
        logic [PERIOD_W-1:0] send_period;
        logic [PERIOD_W-1:0] heartbeat_period;
    } t_cfg;

    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] peer_id;
        logic            peer_new;
        logic            peer_alive;
    } t_item;

    typedef struct packed {
        logic            ann_leader;
        logic [ID_W-1:0] ann_id;
        logic            ann_new;
        logic            ann_alive;
        logic [1:0]      role;
    } t_result;

    // low 'bits' bits set, capped at the field width
    function automatic logic [ID_W-1:0] id_mask(input int bits);
        logic [ID_W-1:0] m;
        for (int i = 0; i < ID_W; i++) begin
            m[i] = (i < bits);
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/leader_election_node.sv
// One node of a simplified bully leader election. Each request on the slave
// stream is either a one-second tick (tuser = 0) or an already parsed peer
// message (tuser = 1). The node moves between election, leader and follower
// roles, and a tick whose send countdown runs out yields one announcement
// request on the master stream; messages never yield one. A request is
// captured in the input register, evaluated against the node state once
// the output register is free or draining and, if it announces, is
// registered in the output register, which presents it on the master
// stream. One request per cycle is sustained; the only thing that slows
// intake is back-pressure from the master side, which holds the output
// register and through it the input register. Configuration writes
// (my_id, election_ticks, leader_ticks, send_period, heartbeat_period at
// indexes 0 to 4) are always accepted and must only be made while the node
// is idle; writes to other indexes are ignored. Identifiers are compared and
// announced on their low ID_BITS bits.
module leader_election_node
    import le_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // [7:0] peer_id, [8] peer_new, [9] peer_alive
    input  logic [0:0]            i_s_tuser,   // [0] action: 0 tick, 1 message
    // master stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,   // [0] ann_leader, [8:1] ann_id, [9] ann_new,
                                               // [10] ann_alive, [12:11] role
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_item   s_item;
    t_result res;
    logic    res_vld;
    logic    s_take;
    logic    proc;

    // input register
    logic    r_in_vld, n_in_vld;
    t_item   r_in,     n_in;
    // output register
    logic    r_out_vld, n_out_vld;
    t_result r_out,     n_out;

    assign o_cfg_ready = 1'b1;

    le_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign s_item.action     = i_s_tuser[0];
    assign s_item.peer_id    = i_s_tdata[ID_W-1:0];
    assign s_item.peer_new   = i_s_tdata[ID_W];
    assign s_item.peer_alive = i_s_tdata[ID_W+1];

    // held request is evaluated once the output slot is free or draining
    assign proc       = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || proc;
    assign s_take     = i_s_tvalid && o_s_tready;

    le_core #(
        .ID_BITS (ID_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (proc),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    always_comb begin
        n_in     = r_in;
        n_in_vld = r_in_vld;
        if (s_take) begin
            n_in     = s_item;
            n_in_vld = 1'b1;
        end else if (proc) begin
            n_in_vld = 1'b0;
        end
    end

    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld;
        if (proc && res_vld) begin
            n_out     = res;
            n_out_vld = 1'b1;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out.role, r_out.ann_alive, r_out.ann_new,
                         r_out.ann_id, r_out.ann_leader};

endmodule

FILE: hw/rtl/le_cfg_regs.sv
module le_cfg_regs
    import le_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_MY_ID:       n_cfg.my_id            = i_data[ID_W-1:0];
                CFG_ELECT_TICKS: n_cfg.election_ticks   = i_data[TICKS_W-1:0];
                CFG_LEAD_TICKS:  n_cfg.leader_ticks     = i_data[TICKS_W-1:0];
                CFG_SEND_PERIOD: n_cfg.send_period      = i_data[PERIOD_W-1:0];
                CFG_HB_PERIOD:   n_cfg.heartbeat_period = i_data[PERIOD_W-1:0];
                default:         n_cfg = r_cfg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.my_id            <= MY_ID_RST;
            r_cfg.election_ticks   <= ELECT_RST;
            r_cfg.leader_ticks     <= LEADER_RST;
            r_cfg.send_period      <= SEND_RST;
            r_cfg.heartbeat_period <= HEARTBEAT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/le_core.sv
module le_core
    import le_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output logic    o_res_vld,
    output t_result o_res
);

    localparam logic [ID_W-1:0] ID_MASK = id_mask(ID_BITS);

    t_role                     r_role,  n_role;
    logic signed [WAIT_W-1:0]  r_wait,  n_wait;
    logic [SEND_W-1:0]         r_send,  n_send;
    logic                      r_lk,    n_lk;
    logic                      r_ba,    n_ba;
    logic                      r_new,   n_new;

    logic [ID_W-1:0]           mine;
    logic [ID_W-1:0]           peer;
    logic signed [WAIT_W-1:0]  elect_load;
    logic signed [WAIT_W-1:0]  lead_load;

    // tick evaluation, shared by next-state and output logic
    t_role                     tk_role;
    logic signed [WAIT_W-1:0]  tk_wait;
    logic [SEND_W-1:0]         tk_send;
    logic                      tk_lk;
    logic                      tk_ba;
    logic                      tk_due;

    assign mine       = i_cfg.my_id & ID_MASK;
    assign peer       = i_item.peer_id & ID_MASK;
    assign elect_load = WAIT_W'({1'b0, i_cfg.election_ticks});
    assign lead_load  = WAIT_W'({1'b0, i_cfg.leader_ticks});

    always_comb begin
        tk_role = r_role;
        tk_lk   = r_lk;
        tk_ba   = r_ba;
        // wait saturates at -1, send at 0
        tk_wait = r_wait[WAIT_W-1] ? r_wait : r_wait - WAIT_W'(1);
        tk_send = (r_send != '0) ? r_send - SEND_W'(1) : r_send;
        if (tk_wait[WAIT_W-1]) begin
            if (r_role == ROLE_ELECTION) begin
                tk_role = ROLE_LEADER;
            end else if (r_role == ROLE_FOLLOWER) begin
                tk_role = ROLE_ELECTION;
                tk_wait = elect_load;
            end
        end
        if (tk_role == ROLE_LEADER) begin
            tk_lk = 1'b1;
            tk_ba = 1'b1;
        end
        tk_due = (tk_send == '0);
    end

    // next state
    always_comb begin
        n_role = r_role;
        n_wait = r_wait;
        n_send = r_send;
        n_lk   = r_lk;
        n_ba   = r_ba;
        n_new  = r_new;
        if (i_fire) begin
            if (i_item.action == ACT_TICK) begin
                n_role = tk_role;
                n_wait = tk_wait;
                n_lk   = tk_lk;
                n_ba   = tk_ba;
                n_send = tk_send;
                if (tk_due) begin
                    n_new  = 1'b0;
                    n_send = (tk_role == ROLE_LEADER) ? SEND_W'(i_cfg.heartbeat_period)
                                                      : SEND_W'(i_cfg.send_period);
                end
            end else begin
                case (r_role)
                    ROLE_ELECTION: begin
                        n_lk = 1'b0;
                        if (mine < peer) begin
                            n_wait = elect_load;
                        end else if (mine > peer) begin
                            n_role = ROLE_FOLLOWER;
                            n_wait = lead_load;
                        end
                    end
                    ROLE_FOLLOWER: begin
                        n_send = {i_cfg.send_period, 1'b0};
                        if (i_item.peer_new) begin
                            n_role = ROLE_ELECTION;
                        end else if (i_item.peer_alive) begin
                            n_wait = lead_load;
                            n_lk   = 1'b1;
                        end
                    end
                    ROLE_LEADER: begin
                        if (i_item.peer_new) begin
                            n_role = ROLE_ELECTION;
                            n_wait = elect_load;
                        end
                    end
                    default: n_role = r_role;
                endcase
            end
        end
    end

    // announcement
    always_comb begin
        o_res_vld        = i_fire && (i_item.action == ACT_TICK) && tk_due;
        o_res.ann_leader = tk_lk;
        o_res.ann_id     = mine;
        o_res.ann_new    = r_new;
        o_res.ann_alive  = tk_ba;
        o_res.role       = tk_role;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role <= ROLE_ELECTION;
            r_wait <= WAIT_W'({1'b0, ELECT_RST});
            r_send <= SEND_W'(SEND_RST);
            r_lk   <= 1'b0;
            r_ba   <= 1'b0;
            r_new  <= 1'b1;
        end else begin
            r_role <= n_role;
            r_wait <= n_wait;
            r_send <= n_send;
            r_lk   <= n_lk;
            r_ba   <= n_ba;
            r_new  <= n_new;
        end
    end

endmodule

FILE: hw/rtl/le_checker.sv
module le_checker
    import le_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_DATA_W-1:0]   o_m_tdata
);

    // stalled announcement holds
    a_m_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("announcement dropped or changed under back-pressure");

    // nothing left over from before reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("announcement present straight after reset");

    // a leader always announces a known, live leader
    a_leader_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[12:11] == ROLE_LEADER) |-> o_m_tdata[0] && o_m_tdata[10])
        else $error("leader announcement without leader or alive flag");

    // role code 3 is never announced, padding stays clear
    a_role_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[12:11] != 2'd3) && (o_m_tdata[15:13] == 3'b000))
        else $error("bad role code or padding in announcement");

endmodule

bind leader_election_node le_checker u_le_checker (.*);
